[design/seven_segment_scan_controller_unit_macros.svh]
// Assertion macros for the seven-segment scan controller.
// Included by the top level; no other dependencies.
`ifndef SEVEN_SEGMENT_SCAN_CONTROLLER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define SSSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SSSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/sssc_pkg.sv]
// Package for the seven-segment scan controller: types, register indexes,
// segment tables and small constant-divisor helpers. No dependencies.
package sssc_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } sssc_state_t;

  typedef enum logic [1:0] {
    KIND_DIGIT  = 2'd0,
    KIND_LETTER = 2'd1,
    KIND_SIGN   = 2'd2,
    KIND_NONE   = 2'd3
  } sssc_kind_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [2:0] CFG_DISPLAY_ENABLE = 3'd0;
  localparam logic [2:0] CFG_FLASH_MODE     = 3'd1;
  localparam logic [2:0] CFG_LEFT_SHOWN     = 3'd2;
  localparam logic [2:0] CFG_RIGHT_SHOWN    = 3'd3;
  localparam logic [2:0] CFG_BLANK_POSITION = 3'd4;
  localparam logic [2:0] CFG_LED_ENABLES    = 3'd5;
  localparam logic [2:0] CFG_MIRROR_MODE    = 3'd6;

  localparam logic [1:0] FLASH_NONE   = 2'd0;
  localparam logic [1:0] FLASH_LEFT   = 2'd1;
  localparam logic [1:0] FLASH_RIGHT  = 2'd2;
  localparam logic [1:0] FLASH_SINGLE = 2'd3;

  localparam int DIGIT_COUNT = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int ENTRY_W    = 10;   // {kind, value}

  // v % 10 via reciprocal multiply; exact for all 8-bit v
  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  tenq;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    q    = prod[15:11];
    tenq = 8'(8'(q) * 8'd10);
    rem  = v - tenq;
    return rem[3:0];
  endfunction

  // (v - 26) % 26 for v >= 26; exact for every such 8-bit v
  function automatic logic [4:0] mod26_low(input logic [7:0] v);
    logic [7:0]  x;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  q26;
    logic [7:0]  rem;
    x    = v - 8'd26;
    prod = 16'(x) * 16'd79;
    q    = prod[15:11];
    q26  = 8'(8'(q) * 8'd26);
    rem  = x - q26;
    return rem[4:0];
  endfunction

  function automatic logic [6:0] seg_digit(input logic [3:0] idx, input logic mir);
    logic [6:0] s;
    unique case (idx)
      4'd0: s = mir ? 7'h3F : 7'h3F;
      4'd1: s = mir ? 7'h30 : 7'h06;
      4'd2: s = mir ? 7'h5B : 7'h5B;
      4'd3: s = mir ? 7'h79 : 7'h4F;
      4'd4: s = mir ? 7'h74 : 7'h66;
      4'd5: s = mir ? 7'h6D : 7'h6D;
      4'd6: s = mir ? 7'h6F : 7'h7D;
      4'd7: s = mir ? 7'h38 : 7'h07;
      4'd8: s = mir ? 7'h7F : 7'h7F;
      4'd9: s = mir ? 7'h7D : 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] seg_letter(input logic [4:0] idx, input logic lower,
                                            input logic mir);
    logic [6:0] s;
    unique case (idx)
      5'd0:  s = mir ? 7'h7E : 7'h77;
      5'd1:  s = mir ? 7'h67 : 7'h7C;
      5'd2:  s = mir ? (lower ? 7'h43 : 7'h0F) : (lower ? 7'h58 : 7'h39);
      5'd3:  s = mir ? 7'h73 : 7'h5E;
      5'd4:  s = mir ? 7'h4F : 7'h79;
      5'd5:  s = mir ? 7'h4E : 7'h71;
      5'd6:  s = mir ? 7'h2F : 7'h3D;
      5'd7:  s = mir ? (lower ? 7'h66 : 7'h76) : (lower ? 7'h74 : 7'h76);
      5'd8:  s = mir ? 7'h20 : 7'h04;
      5'd9:  s = mir ? 7'h33 : 7'h1E;
      5'd10: s = mir ? 7'h57 : 7'h7A;
      5'd11: s = mir ? 7'h07 : 7'h38;
      5'd12: s = mir ? 7'h6A : 7'h55;
      5'd13: s = mir ? 7'h62 : 7'h54;
      5'd14: s = mir ? 7'h63 : 7'h5C;
      5'd15: s = mir ? 7'h5E : 7'h73;
      5'd16: s = mir ? 7'h7C : 7'h67;
      5'd17: s = mir ? 7'h42 : 7'h50;
      5'd18: s = mir ? 7'h6D : 7'h6D;
      5'd19: s = mir ? 7'h47 : 7'h78;
      5'd20, 5'd21, 5'd22:
             s = mir ? (lower ? 7'h23 : 7'h37) : (lower ? 7'h1C : 7'h3E);
      5'd23: s = 7'h76;
      5'd24: s = mir ? (lower ? 7'h6E : 7'h75) : 7'h6E;
      5'd25: s = mir ? (lower ? 7'h75 : 7'h5B) : 7'h5B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] seg_sign(input logic [1:0] idx, input logic mir);
    logic [6:0] s;
    unique case (idx)
      2'd0: s = 7'h00;
      2'd1: s = 7'h40;
      2'd2: s = mir ? 7'h20 : 7'h04;
      2'd3: s = mir ? 7'h30 : 7'h06;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

[design/seven_segment_scan_controller_unit.sv]
// Timing: a write is stored at its accept edge and gives no result; an enabled tick is
// registered as the buffer read word, then decoded into the output register; a disabled
// tick loads the output register at its accept edge. Throughput: writes and disabled
// ticks 1 per cycle; input stalls in ST_READ and while the output is full and held.
// Reset (rst_n, synchronous): registers to defaults, scan position 0, entry valid bits
// cleared so every entry reads as digit zero until written.
`include "seven_segment_scan_controller_unit_macros.svh"

module seven_segment_scan_controller_unit
  import sssc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [3:0]             in_entry_position,
  input  logic [1:0]             in_entry_kind,
  input  logic [7:0]             in_entry_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             out_segments,
  output logic [DIGIT_COUNT-1:0] out_digit_strobe,
  output logic                   out_led_on,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  localparam int POS_W = $clog2(DIGIT_COUNT);

  sssc_state_t state_r, state_nxt;

  logic       display_enable_r;
  logic [1:0] flash_mode_r;
  logic       left_shown_r;
  logic       right_shown_r;
  logic [3:0] blank_position_r;
  logic [2:0] led_enables_r;
  logic       mirror_mode_r;

  logic [ENTRY_W-1:0]     entry_mem [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] entry_vld_r;
  logic [ENTRY_W-1:0]     rd_word_r;
  logic                   rd_vld_r;
  logic [POS_W-1:0]       scan_pos_r, scan_pos_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [6:0]             out_segments_r;
  logic [DIGIT_COUNT-1:0] out_strobe_r;
  logic                   out_led_r;

  logic             in_acc;
  logic             mem_we, mem_re, load_off, load_dec;
  logic [POS_W-1:0] wr_addr;

  logic [1:0]             dec_kind;
  logic [7:0]             dec_value;
  logic [6:0]             dec_seg;
  logic                   dec_shown;
  logic                   dec_led;
  logic [POS_W-1:0]       strobe_bit;
  logic [DIGIT_COUNT-1:0] dec_strobe;

  assign in_acc  = in_valid && !in_stall;
  assign wr_addr = in_entry_position[POS_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_enable_r <= 1'b1;
      flash_mode_r     <= FLASH_NONE;
      left_shown_r     <= 1'b0;
      right_shown_r    <= 1'b0;
      blank_position_r <= 4'(DIGIT_COUNT);
      led_enables_r    <= 3'd0;
      mirror_mode_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DISPLAY_ENABLE: display_enable_r <= cfg_wr_data[0];
        CFG_FLASH_MODE:     flash_mode_r     <= cfg_wr_data[1:0];
        CFG_LEFT_SHOWN:     left_shown_r     <= cfg_wr_data[0];
        CFG_RIGHT_SHOWN:    right_shown_r    <= cfg_wr_data[0];
        CFG_BLANK_POSITION: blank_position_r <= cfg_wr_data[3:0];
        CFG_LED_ENABLES:    led_enables_r    <= cfg_wr_data[2:0];
        CFG_MIRROR_MODE:    mirror_mode_r    <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_func == FUNC_TICK && display_enable_r) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    load_off = 1'b0;
    load_dec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        mem_we   = in_acc && in_func == FUNC_WRITE &&
                   in_entry_position < 4'(DIGIT_COUNT);
        mem_re   = in_acc && in_func == FUNC_TICK && display_enable_r;
        load_off = in_acc && in_func == FUNC_TICK && !display_enable_r;
      end
      ST_READ: load_dec = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // display buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[wr_addr] <= {in_entry_kind, in_entry_value};
    end
    if (mem_re) begin
      rd_word_r <= entry_mem[scan_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (mem_we) entry_vld_r[wr_addr] <= 1'b1;
      if (mem_re) rd_vld_r <= entry_vld_r[scan_pos_r];
    end
  end

  // decode of the entry just read; never-written entries read as digit zero
  always_comb begin
    dec_kind  = rd_vld_r ? rd_word_r[9:8] : KIND_DIGIT;
    dec_value = rd_vld_r ? rd_word_r[7:0] : 8'd0;
    case (dec_kind)
      KIND_DIGIT:  dec_seg = seg_digit(mod10(dec_value), mirror_mode_r);
      KIND_LETTER: begin
        if (dec_value >= 8'd26) dec_seg = seg_letter(mod26_low(dec_value), 1'b1,
                                                     mirror_mode_r);
        else                    dec_seg = seg_letter(dec_value[4:0], 1'b0, mirror_mode_r);
      end
      KIND_SIGN:   dec_seg = seg_sign(dec_value[1:0], mirror_mode_r);
      default:     dec_seg = 7'h00;
    endcase

    dec_shown = 1'b1;
    if (flash_mode_r == FLASH_LEFT && !left_shown_r &&
        scan_pos_r < POS_W'(DIGIT_COUNT / 2)) begin
      dec_shown = 1'b0;
    end else if (flash_mode_r == FLASH_RIGHT && !right_shown_r &&
                 scan_pos_r >= POS_W'(DIGIT_COUNT / 2)) begin
      dec_shown = 1'b0;
    end else if (flash_mode_r == FLASH_SINGLE && blank_position_r < 4'(DIGIT_COUNT) &&
                 scan_pos_r == blank_position_r[POS_W-1:0]) begin
      dec_shown = 1'b0;
    end

    dec_led = (scan_pos_r == POS_W'(0) && led_enables_r[0]) ||
              (scan_pos_r == POS_W'(2) && led_enables_r[1]) ||
              (scan_pos_r == POS_W'(4) && led_enables_r[2]);

    strobe_bit = mirror_mode_r ? POS_W'(DIGIT_COUNT - 1) - scan_pos_r : scan_pos_r;
    dec_strobe = DIGIT_COUNT'(1) << strobe_bit;
  end

  always_comb begin
    scan_pos_nxt = scan_pos_r;
    if (load_dec) begin
      scan_pos_nxt = (scan_pos_r == POS_W'(DIGIT_COUNT - 1)) ? '0 : scan_pos_r + POS_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_off || load_dec)         out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load_off) begin
      out_segments_r <= 7'h00;
      out_strobe_r   <= '0;
      out_led_r      <= 1'b0;
    end else if (load_dec) begin
      out_segments_r <= dec_shown ? dec_seg : 7'h00;
      out_strobe_r   <= dec_strobe;
      out_led_r      <= dec_led;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_segments_r;
  assign out_digit_strobe = out_strobe_r;
  assign out_led_on       = out_led_r;

  `SSSC_ASSERT_NXT(a_tick_reads, clk, rst_n,
    in_acc && in_func == FUNC_TICK && display_enable_r, state_r == ST_READ && !in_stall == 1'b0)
  `SSSC_ASSERT_NXT(a_read_loads, clk, rst_n, state_r == ST_READ, out_valid_r)
  `SSSC_ASSERT_IMP(a_strobe_onehot0, clk, rst_n, out_valid_r, $onehot0(out_strobe_r))
  `SSSC_ASSERT_IMP(a_off_dark, clk, rst_n, out_valid_r && out_strobe_r == '0,
    out_segments_r == 7'h00 && !out_led_r)
  `SSSC_ASSERT_NXT(a_write_holds_pos, clk, rst_n, in_acc && in_func == FUNC_WRITE,
    scan_pos_r == $past(scan_pos_r))

endmodule
